FILE: sv/tbgl_pkg.sv
// tbgl_pkg: shared types, register indexes, character codes and font table
// for the text box glyph layout block
// no dependencies
package tbgl_pkg;

    localparam int CX_W    = 12;
    localparam int CY_W    = 11;
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 3;
    localparam int TAB_W   = 8;
    localparam int DVD_W   = 13;

    // configuration register indexes
    typedef enum logic [CFG_A_W-1:0] {
        CFG_ORIGIN_X     = 3'd0,
        CFG_ORIGIN_Y     = 3'd1,
        CFG_BOX_WIDTH    = 3'd2,
        CFG_BOX_HEIGHT   = 3'd3,
        CFG_LINE_HEIGHT  = 3'd4,
        CFG_SPACE_WIDTH  = 3'd5,
        CFG_TAB_WIDTH    = 3'd6,
        CFG_TEXTURE_BASE = 3'd7
    } cfg_idx_t;

    // character codes
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0a;
    localparam logic [7:0] CHR_CR    = 8'h0d;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_FIRST = 8'h21;
    localparam logic [7:0] CHR_LAST  = 8'h7f;

    localparam logic [3:0] GLYPH_H = 4'd9;

    // cursor state held in the state memory
    typedef struct packed {
        logic [CX_W-1:0] cursor_x;
        logic [CY_W-1:0] cursor_y;
        logic            stopped;
    } tbgl_state_t;

    localparam tbgl_state_t STATE_RESET = '{cursor_x: '0, cursor_y: '0, stopped: 1'b1};

    // glyph widths, indexed by code minus the first printable code
    localparam logic [3:0] GLYPH_W [0:94] = '{
        4'd2, 4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd2, 4'd3, 4'd3, 4'd4, 4'd6, 4'd3, 4'd6, 4'd2,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd2, 4'd3, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd5,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd3, 4'd6, 4'd3, 4'd4, 4'd6, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5,
        4'd6, 4'd5, 4'd2, 4'd4, 4'd5, 4'd2, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5,
        4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd4, 4'd2, 4'd4, 4'd6, 4'd6
    };

endpackage

FILE: sv/tbgl_state_mem.sv
// tbgl_state_mem: single-entry synchronous state memory with a registered read
// uses tbgl_pkg for the state type and its reset value
// an entry never written reads as the reset state
module tbgl_state_mem (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  tbgl_pkg::tbgl_state_t wr_data,
    input  logic                  rd_en,
    output tbgl_pkg::tbgl_state_t rd_data
);

    tbgl_pkg::tbgl_state_t mem [0:0];
    tbgl_pkg::tbgl_state_t rd_data_reg;
    logic                  valid_reg;
    logic                  rd_valid_reg;

    // storage array, no reset
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[0] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[0];
        end
    end

    // entry valid flag and registered read flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : tbgl_pkg::STATE_RESET;

endmodule

FILE: sv/tbgl_tab_div.sv
// tbgl_tab_div: restoring remainder unit, one quotient bit per cycle
// uses tbgl_pkg for operand widths
module tbgl_tab_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [tbgl_pkg::DVD_W-1:0]   dividend,
    input  logic [tbgl_pkg::TAB_W-1:0]   divisor,
    output logic                         done,
    output logic [tbgl_pkg::TAB_W-1:0]   remainder
);

    localparam int CNT_W = $clog2(tbgl_pkg::DVD_W + 1);

    logic [tbgl_pkg::DVD_W-1:0] dvd_reg;
    logic [tbgl_pkg::TAB_W-1:0] dsr_reg;
    logic [tbgl_pkg::TAB_W-1:0] rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [tbgl_pkg::TAB_W:0]   trial;
    logic [tbgl_pkg::TAB_W:0]   diff;

    // one trial subtraction per cycle
    always_comb begin
        trial = {rem_reg, dvd_reg[tbgl_pkg::DVD_W-1]};
        diff  = trial - {1'b0, dsr_reg};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(tbgl_pkg::DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[tbgl_pkg::DVD_W-2:0], 1'b0};
            if (!diff[tbgl_pkg::TAB_W]) begin
                rem_reg <= diff[tbgl_pkg::TAB_W-1:0];
            end else begin
                rem_reg <= trial[tbgl_pkg::TAB_W-1:0];
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: sv/text_box_glyph_layout.sv
// text_box_glyph_layout: one character per transfer, taken only when idle;
// a glyph is registered in ACT (or in EMIT on a stall) and a tab waits on
// the one-bit-per-cycle remainder unit. The cursor state is read from and
// written back to a single-entry state memory for each character.
// Reset (aresetn low, synchronous) loads register defaults and the state
// memory reads as stopped with the cursor at zero until first written.
// depends on tbgl_pkg, tbgl_state_mem, tbgl_tab_div
module text_box_glyph_layout (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [tbgl_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [tbgl_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_char_code,
    input  logic                           s_first_of_string,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [10:0]                    m_screen_x,
    output logic [9:0]                     m_screen_y,
    output logic [7:0]                     m_tex_u,
    output logic [7:0]                     m_tex_v,
    output logic [3:0]                     m_glyph_width,
    output logic [3:0]                     m_glyph_height
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_ACT,
        S_DIV,
        S_EMIT
    } fsm_t;

    fsm_t state_reg;

    // configuration registers
    logic [9:0]  origin_x_reg;
    logic [8:0]  origin_y_reg;
    logic [9:0]  box_width_reg;
    logic [8:0]  box_height_reg;
    logic [7:0]  line_height_reg;
    logic [7:0]  space_width_reg;
    logic [7:0]  tab_width_reg;
    logic [15:0] texture_base_reg;

    // item and working cursor
    logic [7:0]                code_reg;
    logic                      first_reg;
    logic [tbgl_pkg::CX_W-1:0] cx_reg;
    logic [tbgl_pkg::CY_W-1:0] cy_reg;
    logic [tbgl_pkg::DVD_W-1:0] t_reg;

    // output register
    logic        m_valid_reg;
    logic [10:0] screen_x_reg;
    logic [9:0]  screen_y_reg;
    logic [7:0]  tex_u_reg;
    logic [7:0]  tex_v_reg;
    logic [3:0]  glyph_w_reg;

    // state memory ports
    tbgl_pkg::tbgl_state_t mem_rd;
    tbgl_pkg::tbgl_state_t mem_wr;
    logic                  mem_we;
    logic                  accept;

    // remainder unit
    logic                       div_start;
    logic                       div_done;
    logic [tbgl_pkg::TAB_W-1:0] div_rem;

    // evaluation signals
    tbgl_pkg::tbgl_state_t     s0;
    logic [10:0]               right_edge;
    logic                      wrap;
    logic [tbgl_pkg::CX_W-1:0] cx_wrap;
    logic [tbgl_pkg::CY_W-1:0] cy_wrap;
    logic signed [12:0]        rel;
    logic                      past_bottom;
    logic [tbgl_pkg::DVD_W-1:0] t_next;
    logic [tbgl_pkg::DVD_W-1:0] tab_x;
    logic [7:0]                code_fix;
    logic [6:0]                pos;
    logic [6:0]                gidx;
    logic [3:0]                gw;
    logic [7:0]                tex_u_next;
    logic [7:0]                tex_v_next;
    logic                      out_free;
    logic                      is_glyph;
    logic                      emit;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // a glyph enters the output register
    assign emit = out_free && ((state_reg == S_EMIT)
                || (state_reg == S_ACT && !past_bottom && !div_start && is_glyph));

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg     <= 10'd5;
            origin_y_reg     <= 9'd5;
            box_width_reg    <= 10'd310;
            box_height_reg   <= 9'd230;
            line_height_reg  <= 8'd10;
            space_width_reg  <= 8'd4;
            tab_width_reg    <= 8'd32;
            texture_base_reg <= 16'd0;
        end else if (cfg_we) begin
            case (cfg_addr)
                tbgl_pkg::CFG_ORIGIN_X:     origin_x_reg     <= cfg_wdata[9:0];
                tbgl_pkg::CFG_ORIGIN_Y:     origin_y_reg     <= cfg_wdata[8:0];
                tbgl_pkg::CFG_BOX_WIDTH:    box_width_reg    <= cfg_wdata[9:0];
                tbgl_pkg::CFG_BOX_HEIGHT:   box_height_reg   <= cfg_wdata[8:0];
                tbgl_pkg::CFG_LINE_HEIGHT:  line_height_reg  <= cfg_wdata[7:0];
                tbgl_pkg::CFG_SPACE_WIDTH:  space_width_reg  <= cfg_wdata[7:0];
                tbgl_pkg::CFG_TAB_WIDTH:    tab_width_reg    <= cfg_wdata[7:0];
                tbgl_pkg::CFG_TEXTURE_BASE: texture_base_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // start of string and right edge wrap, from the memory read data
    always_comb begin
        s0 = mem_rd;
        if (first_reg) begin
            s0.cursor_x = {2'b00, origin_x_reg};
            s0.cursor_y = {2'b00, origin_y_reg};
            s0.stopped  = 1'b0;
        end
        right_edge = {1'b0, origin_x_reg} + {1'b0, box_width_reg};
        wrap       = s0.cursor_x >= {1'b0, right_edge};
        cx_wrap    = wrap ? {2'b00, origin_x_reg} : s0.cursor_x;
        cy_wrap    = wrap ? (s0.cursor_y + {3'b000, line_height_reg}) : s0.cursor_y;
    end

    // bottom edge test and cursor moves on the registered cursor
    always_comb begin
        rel         = $signed({2'b00, cy_reg}) - $signed({4'b0000, origin_y_reg})
                    + $signed({5'b00000, line_height_reg});
        past_bottom = rel > $signed({4'b0000, box_height_reg});
        t_next      = {1'b0, cx_reg} + {5'b00000, tab_width_reg} - 1'b1;
        tab_x       = t_reg - {5'b00000, div_rem};
    end

    // glyph lookup and texture coordinates
    always_comb begin
        if (code_reg < tbgl_pkg::CHR_FIRST || code_reg > tbgl_pkg::CHR_LAST) begin
            code_fix = tbgl_pkg::CHR_LAST;
        end else begin
            code_fix = code_reg;
        end
        pos        = code_fix[6:0] - tbgl_pkg::CHR_SPACE[6:0];
        gidx       = pos - 7'd1;
        gw         = tbgl_pkg::GLYPH_W[gidx];
        tex_u_next = texture_base_reg[7:0] + ({4'b0000, pos[3:0]} * 8'd6);
        tex_v_next = texture_base_reg[15:8] + ({5'b00000, pos[6:4]} * 8'd9);
        is_glyph   = !((code_reg == tbgl_pkg::CHR_TAB) || (code_reg == tbgl_pkg::CHR_CR)
                    || (code_reg == tbgl_pkg::CHR_LF) || (code_reg == tbgl_pkg::CHR_SPACE));
    end

    // state write-back
    always_comb begin
        mem_we    = 1'b0;
        mem_wr    = s0;
        div_start = 1'b0;
        case (state_reg)
            S_EVAL: begin
                if (s0.stopped) begin
                    mem_we = 1'b1;
                end else if (code_reg == tbgl_pkg::CHR_NUL) begin
                    mem_we         = 1'b1;
                    mem_wr.stopped = 1'b1;
                end
            end
            S_ACT: begin
                mem_wr.cursor_x = cx_reg;
                mem_wr.cursor_y = cy_reg;
                mem_wr.stopped  = 1'b0;
                mem_we          = 1'b1;
                if (past_bottom) begin
                    mem_wr.stopped = 1'b1;
                end else if (code_reg == tbgl_pkg::CHR_TAB) begin
                    if (tab_width_reg != '0) begin
                        mem_we    = 1'b0;
                        div_start = 1'b1;
                    end
                end else if (code_reg == tbgl_pkg::CHR_CR) begin
                    mem_wr.cursor_x = {2'b00, origin_x_reg};
                end else if (code_reg == tbgl_pkg::CHR_LF) begin
                    mem_wr.cursor_x = {2'b00, origin_x_reg};
                    mem_wr.cursor_y = cy_reg + {3'b000, line_height_reg};
                end else if (code_reg == tbgl_pkg::CHR_SPACE) begin
                    mem_wr.cursor_x = cx_reg + {4'b0000, space_width_reg};
                end else begin
                    mem_wr.cursor_x = cx_reg + {8'h00, gw};
                end
            end
            S_DIV: begin
                mem_wr.cursor_x = tab_x[tbgl_pkg::CX_W-1:0];
                mem_wr.cursor_y = cy_reg;
                mem_wr.stopped  = 1'b0;
                mem_we          = div_done;
            end
            default: ;
        endcase
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if ((state_reg == S_ACT || state_reg == S_EMIT) && out_free) begin
                screen_x_reg <= cx_reg[10:0];
                screen_y_reg <= cy_reg[9:0];
                tex_u_reg    <= tex_u_next;
                tex_v_reg    <= tex_v_next;
                glyph_w_reg  <= gw;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (s0.stopped || code_reg == tbgl_pkg::CHR_NUL) begin
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_ACT;
                    end
                end
                S_ACT: begin
                    if (past_bottom) begin
                        state_reg <= S_IDLE;
                    end else if (div_start) begin
                        state_reg <= S_DIV;
                    end else if (is_glyph) begin
                        if (out_free) begin
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= S_EMIT;
                        end
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // item capture and working cursor
    always_ff @(posedge aclk) begin
        if (accept) begin
            code_reg  <= s_char_code;
            first_reg <= s_first_of_string;
        end
        if (state_reg == S_EVAL) begin
            cx_reg <= cx_wrap;
            cy_reg <= cy_wrap;
        end
        if (state_reg == S_ACT) begin
            t_reg <= t_next;
        end
    end

    tbgl_state_mem u_state_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_we),
        .wr_data (mem_wr),
        .rd_en   (accept),
        .rd_data (mem_rd)
    );

    tbgl_tab_div u_tab_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (t_next),
        .divisor   (tab_width_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign m_valid        = m_valid_reg;
    assign m_screen_x     = screen_x_reg;
    assign m_screen_y     = screen_y_reg;
    assign m_tex_u        = tex_u_reg;
    assign m_tex_v        = tex_v_reg;
    assign m_glyph_width  = glyph_w_reg;
    assign m_glyph_height = tbgl_pkg::GLYPH_H;

endmodule

FILE: sv/tbgl_checker.sv
// tbgl_checker: port-level checks on the text box glyph layout block
// bound to text_box_glyph_layout; no package dependency
module tbgl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [10:0] m_screen_x,
    input logic [3:0]  m_glyph_width,
    input logic [3:0]  m_glyph_height
);

    // one character at a time: busy after each input transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a character is in progress");

    // a new result only appears as a character finishes
    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a character in progress");

    // glyph size comes from the font table
    a_glyph_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_glyph_height == 4'd9) && (m_glyph_width >= 4'd2)
                    && (m_glyph_width <= 4'd6))
        else $error("glyph size outside the font table");

    // stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_screen_x))
        else $error("stalled result dropped or changed");

endmodule

bind text_box_glyph_layout tbgl_checker u_tbgl_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_screen_x     (m_screen_x),
    .m_glyph_width  (m_glyph_width),
    .m_glyph_height (m_glyph_height)
);

FILE: tb/sv/tb.sv
// tb: self-checking bench for text_box_glyph_layout; predicts every drawn glyph
// with its own cursor model and matches the result stream in arrival order
// depends on tbgl_pkg and the text_box_glyph_layout rtl
module tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_CHARS = 95;
    localparam int NUM_PHASES  = 8;
    localparam int FONT_ROWS   = 9;

    typedef struct packed {
        logic [10:0] screen_x;
        logic [9:0]  screen_y;
        logic [7:0]  tex_u;
        logic [7:0]  tex_v;
        logic [3:0]  glyph_width;
        logic [3:0]  glyph_height;
    } glyph_t;

    // cursor model, register copy and the glyphs still owed by the block
    class glyph_tracker;
        logic [9:0]  org_x;
        logic [8:0]  org_y;
        logic [9:0]  box_w;
        logic [8:0]  box_h;
        logic [7:0]  line_h;
        logic [7:0]  space_w;
        logic [7:0]  tab_w;
        logic [15:0] tex_base;
        logic [11:0] cur_x;
        logic [10:0] cur_y;
        logic        halted;
        int          font_w [95];
        glyph_t      glyphs_due [$];
        int          mismatches;

        function new();
            org_x      = 10'd5;
            org_y      = 9'd5;
            box_w      = 10'd310;
            box_h      = 9'd230;
            line_h     = 8'd10;
            space_w    = 8'd4;
            tab_w      = 8'd32;
            tex_base   = 16'd0;
            cur_x      = '0;
            cur_y      = '0;
            halted     = 1'b1;
            mismatches = 0;
            font_w = '{
                2, 4, 6, 6, 6, 6, 2, 3, 3, 4, 6, 3, 6, 2, 6,
                6, 6, 6, 6, 6, 6, 6, 6, 6, 6, 2, 3, 6, 6, 6, 6,
                6, 6, 6, 6, 6, 6, 6, 6, 6, 4, 5, 6, 6, 6, 6, 6,
                6, 6, 6, 6, 6, 6, 6, 6, 6, 6, 6, 3, 6, 3, 4, 6,
                3, 6, 6, 6, 6, 6, 5, 6, 5, 2, 4, 5, 2, 6, 5, 6,
                6, 6, 6, 6, 5, 5, 6, 6, 6, 6, 5, 4, 2, 4, 6, 6
            };
        endfunction

        function void write_reg(tbgl_pkg::cfg_idx_t idx, logic [15:0] value);
            case (idx)
                tbgl_pkg::CFG_ORIGIN_X:     org_x    = value[9:0];
                tbgl_pkg::CFG_ORIGIN_Y:     org_y    = value[8:0];
                tbgl_pkg::CFG_BOX_WIDTH:    box_w    = value[9:0];
                tbgl_pkg::CFG_BOX_HEIGHT:   box_h    = value[8:0];
                tbgl_pkg::CFG_LINE_HEIGHT:  line_h   = value[7:0];
                tbgl_pkg::CFG_SPACE_WIDTH:  space_w  = value[7:0];
                tbgl_pkg::CFG_TAB_WIDTH:    tab_w    = value[7:0];
                tbgl_pkg::CFG_TEXTURE_BASE: tex_base = value;
                default: ;
            endcase
        endfunction

        // lay out one accepted character; returns 0 when it was ignored while halted
        function bit take_char(logic [7:0] code, logic first);
            glyph_t     g;
            int         t;
            int         k;
            logic [7:0] c;
            if (first) begin
                cur_x  = 12'(org_x);
                cur_y  = 11'(org_y);
                halted = 1'b0;
            end
            if (halted)
                return 1'b0;
            if (code == tbgl_pkg::CHR_NUL) begin
                halted = 1'b1;
                return 1'b1;
            end
            // wrap once the cursor has reached the right edge
            if (int'(cur_x) >= int'(org_x) + int'(box_w)) begin
                cur_x = 12'(org_x);
                cur_y = cur_y + 11'(line_h);
            end
            // halt once this line would pass the bottom edge
            if (int'(cur_y) - int'(org_y) + int'(line_h) > int'(box_h)) begin
                halted = 1'b1;
                return 1'b1;
            end
            case (code)
                tbgl_pkg::CHR_TAB: begin
                    // absolute tab stops; a zero spacing leaves the cursor alone
                    if (tab_w != 8'd0) begin
                        t     = int'(cur_x) + int'(tab_w) - 1;
                        cur_x = 12'(t - t % int'(tab_w));
                    end
                end
                tbgl_pkg::CHR_CR: begin
                    cur_x = 12'(org_x);
                end
                tbgl_pkg::CHR_LF: begin
                    cur_x = 12'(org_x);
                    cur_y = cur_y + 11'(line_h);
                end
                tbgl_pkg::CHR_SPACE: begin
                    cur_x = cur_x + 12'(space_w);
                end
                default: begin
                    // anything outside the printable range draws the invalid glyph
                    c = (code < tbgl_pkg::CHR_FIRST || code > tbgl_pkg::CHR_LAST)
                        ? tbgl_pkg::CHR_LAST : code;
                    k = int'(c - tbgl_pkg::CHR_FIRST);
                    g.screen_x     = cur_x[10:0];
                    g.screen_y     = cur_y[9:0];
                    g.tex_u        = 8'(int'(tex_base[7:0]) + ((k + 1) % 16) * 6);
                    g.tex_v        = 8'(int'(tex_base[15:8]) + ((k + 1) / 16) * FONT_ROWS);
                    g.glyph_width  = 4'(font_w[k]);
                    g.glyph_height = 4'(FONT_ROWS);
                    glyphs_due.push_back(g);
                    cur_x = cur_x + 12'(font_w[k]);
                end
            endcase
            return 1'b1;
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void match_glyph(glyph_t got);
            glyph_t want;
            if (glyphs_due.size() == 0) begin
                $error("glyph transfer with none expected: x %0d y %0d",
                       got.screen_x, got.screen_y);
                mismatches++;
                return;
            end
            want = glyphs_due.pop_front();
            compare("screen_x", 16'(want.screen_x), 16'(got.screen_x));
            compare("screen_y", 16'(want.screen_y), 16'(got.screen_y));
            compare("tex_u", 16'(want.tex_u), 16'(got.tex_u));
            compare("tex_v", 16'(want.tex_v), 16'(got.tex_v));
            compare("glyph_width", 16'(want.glyph_width), 16'(got.glyph_width));
            compare("glyph_height", 16'(want.glyph_height), 16'(got.glyph_height));
        endfunction

        function bit busy();
            return glyphs_due.size() != 0;
        endfunction

        function void flag_leftovers();
            if (glyphs_due.size() != 0) begin
                $error("%0d expected glyphs never arrived", glyphs_due.size());
                mismatches++;
            end
        endfunction
    endclass

    logic                         aclk              = 1'b0;
    logic                         aresetn           = 1'b0;
    logic                         cfg_we            = 1'b0;
    logic [tbgl_pkg::CFG_A_W-1:0] cfg_addr          = '0;
    logic [tbgl_pkg::CFG_W-1:0]   cfg_wdata         = '0;
    logic                         s_valid           = 1'b0;
    logic                         s_ready;
    logic [7:0]                   s_char_code       = '0;
    logic                         s_first_of_string = 1'b0;
    logic                         m_valid;
    logic                         m_ready           = 1'b0;
    logic [10:0]                  m_screen_x;
    logic [9:0]                   m_screen_y;
    logic [7:0]                   m_tex_u;
    logic [7:0]                   m_tex_v;
    logic [3:0]                   m_glyph_width;
    logic [3:0]                   m_glyph_height;

    glyph_tracker tracker;
    logic [15:0]  reg_val [8];
    int           tx_gap_pct   = 0;
    int           rx_stall_pct = 0;
    bit           hold_req     = 1'b0;
    bit           hold_given   = 1'b0;
    int           hold_left    = 0;
    int           stall_left   = 0;
    int           chars_left   = 0;
    int           chars_done   = 0;
    int           cycle_count  = 0;

    text_box_glyph_layout uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // idle stretch length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure: random stalls plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 99) < rx_stall_pct)
                stall_left = idle_len();
        end
    end

    // check every glyph transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.match_glyph(glyph_t'{m_screen_x, m_screen_y, m_tex_u, m_tex_v,
                                         m_glyph_width, m_glyph_height});
    end

    // offer one character, wait for its transfer, then predict it
    task automatic send_char(input logic [7:0] code, input logic first);
        int gap;
        gap = ($urandom_range(0, 99) < tx_gap_pct) ? idle_len() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid           <= 1'b1;
        s_char_code       <= code;
        s_first_of_string <= first;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        void'(tracker.take_char(code, first));
        chars_done++;
    endtask

    // strings of random text, mostly printable, with a little noise
    task automatic send_random();
        logic [7:0] code;
        logic       first;
        int         r;
        first = 1'b0;
        if (chars_left == 0) begin
            chars_left = ($urandom_range(0, 9) < 8) ? $urandom_range(3, 40)
                                                     : $urandom_range(41, 150);
            first = 1'b1;
        end
        chars_left--;
        r = $urandom_range(0, 99);
        if (chars_left == 0 && $urandom_range(0, 9) < 8)
            code = tbgl_pkg::CHR_NUL;
        else if (r < 68)
            code = 8'($urandom_range(tbgl_pkg::CHR_FIRST, tbgl_pkg::CHR_LAST - 8'd1));
        else if (r < 74)
            code = 8'($urandom_range(tbgl_pkg::CHR_LAST, 8'hff));
        else if (r < 78)
            code = 8'($urandom_range(1, tbgl_pkg::CHR_SPACE - 8'd1));
        else if (r < 85)
            code = tbgl_pkg::CHR_SPACE;
        else if (r < 90)
            code = tbgl_pkg::CHR_TAB;
        else if (r < 95)
            code = tbgl_pkg::CHR_LF;
        else if (r < 98)
            code = tbgl_pkg::CHR_CR;
        else
            code = tbgl_pkg::CHR_NUL;
        // stray string starts
        if ($urandom_range(0, 99) < 3)
            first = 1'b1;
        send_char(code, first);
    endtask

    // stop offering and let the block run dry before touching registers
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.busy())
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apply_setting();
        for (int i = 0; i < 8; i++) begin
            @(negedge aclk);
            cfg_we    <= 1'b1;
            cfg_addr  <= i[tbgl_pkg::CFG_A_W-1:0];
            cfg_wdata <= reg_val[i];
            tracker.write_reg(tbgl_pkg::cfg_idx_t'(i), reg_val[i]);
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic choose_setting(input int phase);
        case (phase)
            0: begin
                reg_val[tbgl_pkg::CFG_ORIGIN_X]     = 16'd5;
                reg_val[tbgl_pkg::CFG_ORIGIN_Y]     = 16'd5;
                reg_val[tbgl_pkg::CFG_BOX_WIDTH]    = 16'd310;
                reg_val[tbgl_pkg::CFG_BOX_HEIGHT]   = 16'd230;
                reg_val[tbgl_pkg::CFG_LINE_HEIGHT]  = 16'd10;
                reg_val[tbgl_pkg::CFG_SPACE_WIDTH]  = 16'd4;
                reg_val[tbgl_pkg::CFG_TAB_WIDTH]    = 16'd32;
                reg_val[tbgl_pkg::CFG_TEXTURE_BASE] = 16'd0;
            end
            1: begin
                reg_val[tbgl_pkg::CFG_ORIGIN_X]     = 16'd1023;
                reg_val[tbgl_pkg::CFG_ORIGIN_Y]     = 16'd511;
                reg_val[tbgl_pkg::CFG_BOX_WIDTH]    = 16'd1023;
                reg_val[tbgl_pkg::CFG_BOX_HEIGHT]   = 16'd511;
                reg_val[tbgl_pkg::CFG_LINE_HEIGHT]  = 16'd255;
                reg_val[tbgl_pkg::CFG_SPACE_WIDTH]  = 16'd255;
                reg_val[tbgl_pkg::CFG_TAB_WIDTH]    = 16'd255;
                reg_val[tbgl_pkg::CFG_TEXTURE_BASE] = 16'hffff;
            end
            2: begin
                for (int i = 0; i < 8; i++)
                    reg_val[i] = 16'd0;
            end
            3, 4, 6: begin
                // cramped boxes so wraps and the bottom edge come often
                reg_val[tbgl_pkg::CFG_ORIGIN_X]     = 16'($urandom_range(0, 1023));
                reg_val[tbgl_pkg::CFG_ORIGIN_Y]     = 16'($urandom_range(0, 511));
                reg_val[tbgl_pkg::CFG_BOX_WIDTH]    = 16'($urandom_range(0, 80));
                reg_val[tbgl_pkg::CFG_BOX_HEIGHT]   = 16'($urandom_range(0, 60));
                reg_val[tbgl_pkg::CFG_LINE_HEIGHT]  = 16'($urandom_range(0, 20));
                reg_val[tbgl_pkg::CFG_SPACE_WIDTH]  = 16'($urandom_range(0, 12));
                reg_val[tbgl_pkg::CFG_TAB_WIDTH]    = 16'($urandom_range(0, 24));
                reg_val[tbgl_pkg::CFG_TEXTURE_BASE] = 16'($urandom_range(0, 65535));
            end
            5: begin
                reg_val[tbgl_pkg::CFG_ORIGIN_X]     = 16'($urandom_range(0, 1023));
                reg_val[tbgl_pkg::CFG_ORIGIN_Y]     = 16'($urandom_range(0, 511));
                reg_val[tbgl_pkg::CFG_BOX_WIDTH]    = 16'($urandom_range(0, 1023));
                reg_val[tbgl_pkg::CFG_BOX_HEIGHT]   = 16'($urandom_range(0, 511));
                reg_val[tbgl_pkg::CFG_LINE_HEIGHT]  = 16'($urandom_range(0, 255));
                reg_val[tbgl_pkg::CFG_SPACE_WIDTH]  = 16'($urandom_range(0, 255));
                reg_val[tbgl_pkg::CFG_TAB_WIDTH]    = 16'($urandom_range(0, 255));
                reg_val[tbgl_pkg::CFG_TEXTURE_BASE] = 16'($urandom_range(0, 65535));
            end
            default: begin
                reg_val[tbgl_pkg::CFG_ORIGIN_X]     = 16'($urandom_range(0, 1023));
                reg_val[tbgl_pkg::CFG_ORIGIN_Y]     = 16'($urandom_range(0, 511));
                reg_val[tbgl_pkg::CFG_BOX_WIDTH]    = 16'($urandom_range(100, 400));
                reg_val[tbgl_pkg::CFG_BOX_HEIGHT]   = 16'($urandom_range(50, 200));
                reg_val[tbgl_pkg::CFG_LINE_HEIGHT]  = 16'($urandom_range(8, 16));
                reg_val[tbgl_pkg::CFG_SPACE_WIDTH]  = 16'($urandom_range(2, 8));
                reg_val[tbgl_pkg::CFG_TAB_WIDTH]    = 16'($urandom_range(8, 64));
                reg_val[tbgl_pkg::CFG_TEXTURE_BASE] = 16'($urandom_range(0, 65535));
            end
        endcase
    endtask

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        tracker = new();
        repeat (8) @(negedge aclk);
        aresetn      <= 1'b1;
        tx_gap_pct   = 30;
        rx_stall_pct = 30;

        // register defaults: every kind of code, string end, ignored characters
        send_char(8'h41, 1'b0);
        send_char(tbgl_pkg::CHR_FIRST, 1'b1);
        send_char(tbgl_pkg::CHR_LAST, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'hff, 1'b0);
        send_char(8'h01, 1'b0);
        send_char(tbgl_pkg::CHR_TAB, 1'b0);
        send_char(8'h7e, 1'b0);
        send_char(tbgl_pkg::CHR_SPACE, 1'b0);
        send_char(tbgl_pkg::CHR_CR, 1'b0);
        send_char(tbgl_pkg::CHR_LF, 1'b0);
        send_char(8'h57, 1'b0);
        send_char(tbgl_pkg::CHR_NUL, 1'b0);
        send_char(8'h42, 1'b0);
        send_char(tbgl_pkg::CHR_NUL, 1'b1);
        send_char(8'h5a, 1'b1);
        settle();

        // tiny box at the far corner: wrap, bottom edge, zero tab spacing
        reg_val[tbgl_pkg::CFG_ORIGIN_X]     = 16'd1023;
        reg_val[tbgl_pkg::CFG_ORIGIN_Y]     = 16'd511;
        reg_val[tbgl_pkg::CFG_BOX_WIDTH]    = 16'd8;
        reg_val[tbgl_pkg::CFG_BOX_HEIGHT]   = 16'd20;
        reg_val[tbgl_pkg::CFG_LINE_HEIGHT]  = 16'd9;
        reg_val[tbgl_pkg::CFG_SPACE_WIDTH]  = 16'd255;
        reg_val[tbgl_pkg::CFG_TAB_WIDTH]    = 16'd0;
        reg_val[tbgl_pkg::CFG_TEXTURE_BASE] = 16'hffff;
        apply_setting();
        send_char(8'h4d, 1'b1);
        repeat (5) send_char(8'h4d, 1'b0);
        send_char(tbgl_pkg::CHR_TAB, 1'b1);
        send_char(tbgl_pkg::CHR_SPACE, 1'b0);
        send_char(8'h69, 1'b0);

        // random phases; strings run on across register changes
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            choose_setting(p);
            apply_setting();
            tx_gap_pct   = $urandom_range(5, 60);
            rx_stall_pct = $urandom_range(5, 60);
            if (p == 0)
                tx_gap_pct = 0;
            if (p == 6) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            chars_done = 0;
            while (chars_done < PHASE_CHARS) begin
                // long hold-off on the result side while characters keep coming
                if (p == 0 && chars_done >= 20 && !hold_given) begin
                    hold_req   = 1'b1;
                    hold_given = 1'b1;
                end
                send_random();
            end
        end

        settle();
        tracker.flag_leftovers();
        if (tracker.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
